[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication with overlap, off while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	`ASSERT_CLK(label, clk, rst_n, (pre) |-> (post), msg)

// Check an implication in the next cycle, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	`ASSERT_CLK(label, clk, rst_n, (pre) |=> (post), msg)

`endif

[hw/rtl/ttrc_pkg.sv]
// Types and constants of the three-term recurrence checksum.
package ttrc_pkg;

	localparam int unsigned TermW  = 16;
	localparam int unsigned IndexW = 8;

	// Offset added to the first byte of a message.
	localparam logic [7:0]  FIRST_OFFSET = 8'd7;
	// Index multipliers, taken modulo 256.
	localparam logic [7:0]  STEP_A = 8'd17;
	localparam logic [7:0]  STEP_M = 8'd31;
	// 256 * 65535: lifts the widest negative difference above zero.
	localparam logic [26:0] LIFT = 27'd16776960;
	localparam logic [15:0] MODULUS = 16'hFFFF;

	typedef struct packed {
		logic [TermW-1:0]  prev;
		logic [TermW-1:0]  cur;
		logic [IndexW-1:0] idx;
	} term_state_t;

endpackage

[hw/rtl/ttrc_term.sv]
// Next-state logic of the recurrence: one byte applied to the term state.
module ttrc_term (
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	input  ttrc_pkg::term_state_t state_cur,
	output ttrc_pkg::term_state_t state_nxt
);
	import ttrc_pkg::*;

	logic [7:0]  mul_a;
	logic [7:0]  mul_m;
	logic [8:0]  byte_sum;
	logic [24:0] prod_p;
	logic [23:0] prod_q;
	logic        borrow;
	logic [26:0] lifted;
	logic [16:0] fold_a;
	logic [16:0] fold_b;
	logic [15:0] term;

	// 8-bit products keep only the index multiples modulo 256.
	assign mul_a    = state_cur.idx * STEP_A;
	assign mul_m    = state_cur.idx * STEP_M;
	assign byte_sum = {1'b0, data_byte} + {1'b0, mul_a};
	assign prod_p   = {16'b0, byte_sum} * {9'b0, state_cur.cur};
	assign prod_q   = {16'b0, mul_m} * {8'b0, state_cur.prev};

	// A wrapped negative difference is one higher modulo 65535.
	assign borrow = ({1'b0, prod_q} > prod_p);
	assign lifted = {2'b0, prod_p} + LIFT + {26'b0, borrow} - {3'b0, prod_q};

	// Fold 2^16 == 1 twice; the second fold never carries.
	assign fold_a = {1'b0, lifted[15:0]} + {6'b0, lifted[26:16]};
	assign fold_b = {1'b0, fold_a[15:0]} + {16'b0, fold_a[16]};
	assign term   = (fold_b[15:0] == MODULUS) ? 16'd0 : fold_b[15:0];

	always_comb begin
		if (first_byte) begin
			state_nxt.prev = 16'd1;
			state_nxt.cur  = {8'b0, data_byte} + {8'b0, FIRST_OFFSET};
			state_nxt.idx  = 8'd1;
		end else begin
			state_nxt.prev = state_cur.cur;
			state_nxt.cur  = term;
			state_nxt.idx  = state_cur.idx + 8'd1;
		end
	end

endmodule

[hw/rtl/three_term_recurrence_checksum.sv]
// Top level of the three-term recurrence checksum.
//
// Input channel: in_valid/in_ready carry one word per message byte with
// data_byte, first_byte and last_byte. Output channel: out_valid/out_ready
// carry one checksum word for every byte marked last_byte.
// Throughput: one word per cycle, except while a last byte waits behind a
// stalled checksum. The recurrence (two small multiplies and a fold modulo
// 65535) is combinational from the term registers back to themselves.
// Path: a word taken sits in the input register, then updates the terms
// and, when last, loads the checksum register that drives out_valid.
// Reset: terms go to prev 1, cur 1, index 0; both registers empty.
// A byte without first_byte continues from the present terms.
// Stall: while a checksum waits on out_ready, bytes that are not last keep
// flowing through; a last byte waits in the input register, and in_ready
// drops only while such a byte is held behind a stalled checksum.
module three_term_recurrence_checksum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] checksum
);
	import ttrc_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic        last_s1;

	term_state_t state_q;
	term_state_t state_nxt;

	logic        out_valid_q;
	logic [15:0] checksum_q;

	logic        out_free;
	logic        advance;
	logic        take_in;

	ttrc_term u_term (
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.state_cur  (state_q),
		.state_nxt  (state_nxt)
	);

	// The output register can load when empty or draining this cycle.
	assign out_free = !out_valid_q || out_ready;
	// Advance the held byte unless it is last and the checksum slot is busy.
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;
	assign take_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	// Advance the terms once per byte leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.prev <= 16'd1;
			state_q.cur  <= 16'd1;
			state_q.idx  <= 8'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the new current term as the checksum of a last byte.
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			checksum_q <= state_nxt.cur;
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

endmodule

[hw/rtl/ttrc_checker.sv]
// Port-level assertions for the checksum block, bound to the top level.
`include "assert_macros.svh"

module ttrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] checksum
);

	// A reduced term never reaches the modulus.
	`ASSERT_IMPL(a_checksum_range, clk, arst_n, out_valid, checksum != 16'hFFFF, "checksum out of range")

	// Hold a stalled checksum word.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(checksum), "stalled checksum changed")

	// Drop in_ready only behind a stalled checksum.
	`ASSERT_IMPL(a_ready_stall, clk, arst_n, !in_ready, out_valid && !out_ready, "input blocked without output stall")

	// With the output empty, never block the input.
	`ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready, "input blocked while output empty")

endmodule

bind three_term_recurrence_checksum ttrc_checker u_ttrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.checksum  (checksum)
);
